// ===== hdl/brf_pkg.sv =====
package brf_pkg;

    localparam int DEPTH       = 1024;
    localparam int MAX_REQUEST = 64;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int RING_W = PTR_W + 1;
    localparam int CNT_W  = $clog2(MAX_REQUEST + 1);

    localparam int CAP_W  = 11;
    localparam int REQ_W  = 7;
    localparam int ACC_W  = 10;
    localparam int USED_W = 10;
    localparam int FREE_W = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_STAT = 2'd2;

    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_STAT
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_DEQ
    } t_state;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       data_byte;
        logic             run_last;
        logic [REQ_W-1:0] request_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              last_result;
        logic [ACC_W-1:0]  accepted_count;
        logic [USED_W-1:0] used_count;
        logic [FREE_W-1:0] free_count;
    } t_out_item;

    typedef struct packed {
        t_op              op;
        logic [7:0]       data_byte;
        logic             run_last;
        logic [REQ_W-1:0] request_count;
    } t_cmd;

    function automatic logic [RING_W-1:0] ring_size(input logic [CAP_W-1:0] cap);
        logic [RING_W-1:0] r;
        if (32'(cap) < 32'd2) begin
            r = RING_W'(2);
        end else if (32'(cap) > 32'(DEPTH)) begin
            r = RING_W'(DEPTH);
        end else begin
            r = RING_W'(cap);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                     input logic [RING_W-1:0] ring);
        logic [RING_W-1:0] nx;
        nx = RING_W'(p) + RING_W'(1);
        return (nx >= ring) ? '0 : PTR_W'(nx);
    endfunction

endpackage

// ===== hdl/brf_front.sv =====
module brf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  brf_pkg::t_in_item i_in_data,
    output logic            o_cmd_valid,
    output brf_pkg::t_cmd   o_cmd,
    input  logic            i_pop
);
    import brf_pkg::*;

    t_cmd       r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       keep;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    always_comb begin
        keep                 = 1'b1;
        cmd_in.op            = OP_ENQ;
        cmd_in.data_byte     = i_in_data.data_byte;
        cmd_in.run_last      = i_in_data.run_last;
        cmd_in.request_count = i_in_data.request_count;
        case (i_in_data.action)
            ACT_ENQ:  cmd_in.op = OP_ENQ;
            ACT_DEQ:  cmd_in.op = OP_DEQ;
            ACT_STAT: cmd_in.op = OP_STAT;
            default:  keep = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign push        = i_in_valid && !o_in_stall && keep;
    assign pop         = i_pop && (r_count != 2'd0);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ===== hdl/brf_back.sv =====
module brf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  brf_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    input  logic [brf_pkg::RING_W-1:0] i_ring,
    input  logic                       i_cfg_clear,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output brf_pkg::t_out_item         o_out_data
);
    import brf_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_tp, n_tp;
    logic [RING_W-1:0] r_len, n_len;
    logic              r_cancel, n_cancel;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              out_free;
    logic              take;
    logic [RING_W-1:0] used;
    logic [REQ_W-1:0]  req_sat;
    logic [CNT_W-1:0]  deq_n;
    logic [PTR_W-1:0]  tp_adv;
    logic              cancel_now;
    logic              mem_we;
    logic              mem_re;

    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = (r_state == ST_IDLE) && i_cmd_valid && out_free;
    assign tp_adv   = ptr_advance(r_tp, i_ring);

    always_comb begin
        if (r_wp >= r_rp) begin
            used = RING_W'(r_wp) - RING_W'(r_rp);
        end else begin
            used = RING_W'(r_wp) + i_ring - RING_W'(r_rp);
        end
        req_sat = (32'(i_cmd.request_count) > 32'(MAX_REQUEST))
                ? REQ_W'(MAX_REQUEST) : i_cmd.request_count;
        if (RING_W'(req_sat) > used) begin
            deq_n = CNT_W'(used);
        end else begin
            deq_n = CNT_W'(req_sat);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take && i_cmd.op == OP_DEQ && deq_n != '0) begin
                    n_state = ST_DEQ;
                end
            end
            ST_DEQ: begin
                if (out_free && r_rem == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_tp        = r_tp;
        n_len       = r_len;
        n_cancel    = r_cancel;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        cancel_now  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    o_pop = 1'b1;
                    n_out = '0;
                    case (i_cmd.op)
                        OP_ENQ: begin
                            if (!r_cancel) begin
                                mem_we     = 1'b1;
                                n_tp       = tp_adv;
                                n_len      = r_len + RING_W'(1);
                                cancel_now = (tp_adv == r_rp);
                                n_cancel   = cancel_now;
                            end
                            if (i_cmd.run_last) begin
                                n_out_valid       = 1'b1;
                                n_out.last_result = 1'b1;
                                if (!(r_cancel || cancel_now)) begin
                                    n_wp                 = tp_adv;
                                    n_tp                 = tp_adv;
                                    n_out.accepted_count = ACC_W'(r_len + RING_W'(1));
                                end else begin
                                    n_tp = r_wp;
                                end
                                n_len    = '0;
                                n_cancel = 1'b0;
                            end
                        end
                        OP_DEQ: begin
                            if (deq_n == '0) begin
                                n_out_valid       = 1'b1;
                                n_out.last_result = 1'b1;
                            end else begin
                                mem_re = 1'b1;
                                n_rp   = ptr_advance(r_rp, i_ring);
                                n_rem  = deq_n;
                            end
                        end
                        OP_STAT: begin
                            n_out_valid       = 1'b1;
                            n_out.last_result = 1'b1;
                            n_out.used_count  = USED_W'(used);
                            n_out.free_count  = FREE_W'(i_ring - used);
                        end
                        default: n_out_valid = r_out_valid && i_out_stall;
                    endcase
                end
            end
            ST_DEQ: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.out_byte    = r_rdata;
                    n_out.byte_valid  = 1'b1;
                    n_out.last_result = (r_rem == CNT_W'(1));
                    n_rem             = r_rem - CNT_W'(1);
                    if (r_rem != CNT_W'(1)) begin
                        mem_re = 1'b1;
                        n_rp   = ptr_advance(r_rp, i_ring);
                    end
                end
            end
            default: n_out_valid = 1'b0;
        endcase
        if (i_cfg_clear) begin
            n_rp     = '0;
            n_wp     = '0;
            n_tp     = '0;
            n_len    = '0;
            n_cancel = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_tp        <= '0;
            r_len       <= '0;
            r_cancel    <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_tp        <= n_tp;
            r_len       <= n_len;
            r_cancel    <= n_cancel;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tp] <= i_cmd.data_byte;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_rp];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/byte_ring_fifo_atomic_enqueue_unit.sv =====
// Byte ring FIFO with all-or-nothing enqueue runs.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction per
// enqueue byte, dequeue request or status query. A two-entry command queue
// takes transactions while the execution side is busy; action 3 is dropped.
// Output channel (o_out_valid / i_out_stall / o_out_data): result
// transactions from a single output register.
// Execution: the execution side takes no new command while a dequeue is
// emitting bytes; a dequeue reads through the registered read of the byte
// memory (one read issued per emitted byte, first read ahead).
// An accepted transaction is registered in the command queue and its result
// in the output register; a dequeued byte also passes the read register.
// When i_out_stall is high the output register holds, the execution side
// waits and the command queue fills, then o_in_stall rises.
// Reset clears the pointers, the open run and the queues; capacity returns
// to 1024. Memory contents are not cleared. The APB register at address 0
// holds capacity_in_use; writing it clears all pointers and any open run.
// The user must write it only while the block is idle; it is not enforced.
module byte_ring_fifo_atomic_enqueue_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  brf_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output brf_pkg::t_out_item        o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import brf_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);
    assign prdata = (paddr == ADDR_CAPACITY) ? 32'(r_capacity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    brf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    brf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .i_ring      (ring_size(r_capacity)),
        .i_cfg_clear (cfg_wr),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/brf_checker.sv =====
module brf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input brf_pkg::t_out_item o_out_data
);
    import brf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |-> o_out_data.last_result)
        else $error("non-byte result without last marker");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_valid |->
            o_out_data.accepted_count == '0 && o_out_data.used_count == '0 &&
            o_out_data.free_count == '0)
        else $error("byte result carries count fields");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.free_count != '0 |->
            !o_out_data.byte_valid && o_out_data.accepted_count == '0)
        else $error("status result mixed with other fields");

endmodule

bind byte_ring_fifo_atomic_enqueue_unit brf_checker u_brf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/byte_ring_fifo_checker.sv =====
`timescale 1ns / 1ps

module byte_ring_fifo_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  brf_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  brf_pkg::t_out_item i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic [31:0]        i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_commits,
    output int                 o_cancels,
    output int                 o_bytes_out
);
    import brf_pkg::*;

    logic [7:0]       ring_mem [DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] tent_ptr;
    int unsigned      run_len;
    logic             run_dropped;
    logic [CAP_W-1:0] capacity;
    t_out_item        due_results [$];

    function automatic int unsigned ring_len();
        if (capacity < CAP_W'(2)) return 2;
        if (capacity > CAP_W'(DEPTH)) return DEPTH;
        return int'(capacity);
    endfunction

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
        int unsigned nxt;
        nxt = int'(p) + 1;
        if (nxt >= ring_len()) nxt = 0;
        return PTR_W'(nxt);
    endfunction

    function automatic int unsigned held_bytes();
        if (wr_ptr >= rd_ptr) return 32'(wr_ptr) - 32'(rd_ptr);
        return 32'(wr_ptr) + ring_len() - 32'(rd_ptr);
    endfunction

    task automatic clear_ring();
        rd_ptr      = '0;
        wr_ptr      = '0;
        tent_ptr    = '0;
        run_len     = 0;
        run_dropped = 1'b0;
    endtask

    task automatic step_ring(input t_in_item item);
        t_out_item   res;
        int unsigned n;
        int unsigned k;
        res = '0;
        res.last_result = 1'b1;
        case (item.action)
            ACT_ENQ: begin
                if (!run_dropped) begin
                    ring_mem[tent_ptr] = item.data_byte;
                    tent_ptr = step_ptr(tent_ptr);
                    run_len++;
                    if (tent_ptr == rd_ptr) run_dropped = 1'b1;
                end
                if (item.run_last) begin
                    if (!run_dropped) begin
                        wr_ptr = tent_ptr;
                        res.accepted_count = ACC_W'(run_len);
                        o_commits++;
                    end else begin
                        o_cancels++;
                    end
                    tent_ptr    = wr_ptr;
                    run_len     = 0;
                    run_dropped = 1'b0;
                    due_results.push_back(res);
                end
            end
            ACT_DEQ: begin
                n = (item.request_count > MAX_REQUEST) ? MAX_REQUEST : item.request_count;
                if (n > held_bytes()) n = held_bytes();
                if (n == 0) due_results.push_back(res);
                for (k = 0; k < n; k++) begin
                    res.out_byte    = ring_mem[rd_ptr];
                    res.byte_valid  = 1'b1;
                    res.last_result = (k + 1 == n);
                    rd_ptr = step_ptr(rd_ptr);
                    due_results.push_back(res);
                    o_bytes_out++;
                end
            end
            ACT_STAT: begin
                res.used_count = USED_W'(held_bytes());
                res.free_count = FREE_W'(ring_len() - held_bytes());
                due_results.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            capacity = CAP_RESET;
            clear_ring();
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_CAPACITY) begin
                if (i_pwrite) begin
                    capacity = i_pwdata[CAP_W-1:0];
                    clear_ring();
                end else begin
                    check_field("capacity_in_use", 32'(capacity), 32'(i_prdata[CAP_W-1:0]));
                end
            end
            if (i_in_valid && !i_in_stall) step_ring(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with nothing expected: %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(i_out_data.out_byte));
                    check_field("byte_valid", 32'(want.byte_valid),
                                32'(i_out_data.byte_valid));
                    check_field("last_result", 32'(want.last_result),
                                32'(i_out_data.last_result));
                    check_field("accepted_count", 32'(want.accepted_count),
                                32'(i_out_data.accepted_count));
                    check_field("used_count", 32'(want.used_count),
                                32'(i_out_data.used_count));
                    check_field("free_count", 32'(want.free_count),
                                32'(i_out_data.free_count));
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

// ===== tb/byte_ring_fifo_atomic_enqueue_unit_tb.sv =====
`timescale 1ns / 1ps

module byte_ring_fifo_atomic_enqueue_unit_tb;
    import brf_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         PHASE_ITEMS    = 50;
    localparam int         NUM_PHASES     = 9;
    localparam int         MAX_GAP        = 14;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int commits;
    int cancels;
    int bytes_out;
    int sent [4];
    int idle_cycles;
    int settings_run;
    bit in_calm;
    bit out_calm;
    logic [CAP_W-1:0] cap_plan [NUM_PHASES];

    byte_ring_fifo_atomic_enqueue_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    byte_ring_fifo_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_commits    (commits),
        .o_cancels    (cancels),
        .o_bytes_out  (bytes_out)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("byte_ring_fifo_atomic_enqueue_unit_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_stall
        int hold;
        forever begin
            if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
            hold = out_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [1:0] action, input logic [7:0] data,
                             input logic last, input logic [REQ_W-1:0] req);
        t_in_item item;
        int       gap;
        item.action        = action;
        item.data_byte     = data;
        item.run_last      = last;
        item.request_count = req;
        if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent[action]++;
    endtask

    task automatic enq(input logic [7:0] data, input logic last);
        send_item(ACT_ENQ, data, last, REQ_W'($urandom));
    endtask

    task automatic deq(input logic [REQ_W-1:0] req);
        send_item(ACT_DEQ, 8'($urandom), 1'($urandom), req);
    endtask

    task automatic stat();
        send_item(ACT_STAT, 8'($urandom), 1'($urandom), REQ_W'($urandom));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= ADDR_CAPACITY;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_run++;
    endtask

    task automatic random_phase(input int unsigned ring);
        int count;
        int len;
        int pick;
        int k;
        count = 0;
        while (count < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 3) == 0) begin
                    len = $urandom_range(1, (ring + 2 < 80) ? ring + 2 : 80);
                end else begin
                    len = $urandom_range(1, (ring < 12) ? ring : 12);
                end
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        if ($urandom_range(0, 1) == 1) deq(REQ_W'($urandom_range(0, 8)));
                        else stat();
                        count++;
                    end
                    enq(8'($urandom), k == len - 1);
                end
                count += len;
            end else if (pick < 75) begin
                if ($urandom_range(0, 4) == 0) deq(REQ_W'($urandom));
                else deq(REQ_W'($urandom_range(0, 16)));
                count++;
            end else if (pick < 90) begin
                stat();
                count++;
            end else if (pick < 95) begin
                send_item(ACT_UNUSED, 8'($urandom), 1'($urandom), REQ_W'($urandom));
            end else begin
                enq(8'($urandom), 1'b1);
                count++;
            end
        end
    endtask

    initial begin
        int p;
        int ring;
        cap_plan[0] = 11'd2;
        cap_plan[1] = 11'd0;
        cap_plan[2] = 11'd1;
        cap_plan[3] = 11'd3;
        cap_plan[4] = 11'd9;
        cap_plan[5] = 11'd33;
        cap_plan[6] = 11'd2047;
        cap_plan[7] = 11'd1024;
        cap_plan[8] = CAP_W'($urandom_range(34, 1023));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stat();
        deq(7'd0);
        deq(7'd5);
        enq(8'h00, 1'b1);
        enq(8'hFF, 1'b0);
        enq(8'hA5, 1'b0);
        enq(8'h5A, 1'b1);
        send_item(ACT_UNUSED, 8'hFF, 1'b1, 7'h7F);
        stat();
        deq(7'd127);
        deq(7'd64);
        settle();

        write_capacity(11'd4);
        enq(8'h11, 1'b0);
        enq(8'h22, 1'b0);
        enq(8'h33, 1'b0);
        enq(8'h44, 1'b1);
        enq(8'h01, 1'b0);
        enq(8'h80, 1'b0);
        enq(8'h7E, 1'b1);
        stat();
        deq(7'd2);
        enq(8'hC3, 1'b0);
        deq(7'd1);
        enq(8'h3C, 1'b1);
        enq(8'h96, 1'b1);
        enq(8'h69, 1'b1);
        deq(7'd64);
        settle();

        for (p = 0; p < NUM_PHASES; p++) begin
            write_capacity(cap_plan[p]);
            ring = (cap_plan[p] < 2) ? 2 : (cap_plan[p] > DEPTH) ? DEPTH : int'(cap_plan[p]);
            random_phase(ring);
            settle();
        end

        $display("sent %0d enqueue bytes, %0d dequeues, %0d queries, %0d unused actions",
                 sent[ACT_ENQ], sent[ACT_DEQ], sent[ACT_STAT], sent[ACT_UNUSED]);
        $display("%0d capacity writes; %0d runs committed, %0d cancelled, %0d bytes read out",
                 settings_run, commits, cancels, bytes_out);
        if (fail_count == 0) begin
            $display("byte_ring_fifo_atomic_enqueue_unit_tb: PASS");
        end else begin
            $display("byte_ring_fifo_atomic_enqueue_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
